// ===== src/dam_pkg.sv =====
// ----------------------------------------------------------------------------
// dam_pkg - calendar date/time plus minute offset: shared types and constants
// Word layouts, calendar tables and reciprocal constants for the pipeline.
// ----------------------------------------------------------------------------
package dam_pkg;

  localparam int MAX_YEAR = 9999;

  typedef struct packed {
    logic [4:0]         day;
    logic [3:0]         month;
    logic [13:0]        year;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic signed [31:0] offset_minutes;
  } dam_in_t;

  typedef struct packed {
    logic        input_valid;
    logic [32:0] absolute_minutes;
    logic        out_of_range;
    logic [4:0]  res_day;
    logic [3:0]  res_month;
    logic [13:0] res_year;
    logic [4:0]  res_hour;
    logic [5:0]  res_minute;
  } dam_out_t;

  // days before year y, elaboration only
  function automatic longint days_before_year_c(longint y);
    longint p;
    p = y - 1;
    return p * 365 + p / 4 - p / 100 + p / 400;
  endfunction

  function automatic logic [4:0] month_len(logic [3:0] m, logic leap);
    logic [4:0] n;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      4'd2:                                       n = leap ? 5'd29 : 5'd28;
      default:                                    n = 5'd0;
    endcase
    return n;
  endfunction

  // days in the year before the first of month m
  function automatic logic [8:0] cum_before(logic [3:0] m, logic leap);
    logic [8:0] n;
    case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    if (leap && m > 4'd2) n = n + 9'd1;
    return n;
  endfunction

  // reciprocals: x / C == (x * M) >> K for every x of the stated width
  localparam int K100 = 21;    // 14-bit years by 100
  localparam logic [14:0] M100 = 15'(((64'd1 << K100) + 64'd99) / 64'd100);
  localparam int K45 = 34;     // 28-bit values by 45
  localparam logic [28:0] M45 = 29'(((64'd1 << K45) + 64'd44) / 64'd45);
  localparam int K400Y = 43;   // 25-bit day counts by 146097
  localparam logic [25:0] M400Y = 26'(((64'd1 << K400Y) + 64'd146096) / 64'd146097);
  localparam int K100Y = 34;   // 18-bit by 36524
  localparam logic [18:0] M100Y = 19'(((64'd1 << K100Y) + 64'd36523) / 64'd36524);
  localparam int K4Y = 27;     // 16-bit by 1461
  localparam logic [16:0] M4Y = 17'(((64'd1 << K4Y) + 64'd1460) / 64'd1461);
  localparam int K1Y = 20;     // 11-bit by 365
  localparam logic [11:0] M1Y = 12'(((64'd1 << K1Y) + 64'd364) / 64'd365);
  localparam int K60 = 16;     // minute of day (below 1440) by 60
  localparam logic [10:0] M60 = 11'(((64'd1 << K60) + 64'd59) / 64'd60);

  // offset bias in whole days, keeps the biased offset non-negative
  localparam int OFF_BIAS_DAYS = 1491309;
  localparam int DAY_MAX = int'(days_before_year_c(longint'(MAX_YEAR) + 1));

endpackage

// ===== src/datetime_add_minutes.sv =====
// ----------------------------------------------------------------------------
// datetime_add_minutes - Gregorian date/time plus signed minute offset
// Checks the date, forms absolute minutes, adds the offset, converts back.
// ----------------------------------------------------------------------------
//   channel | signals                | word
//   --------+------------------------+-----------
//   in      | ts_valid, ts_stall     | dam_in_t
//   out     | res_valid, res_stall   | dam_out_t
//
// Thirteen register stages; one word enters per cycle while the result is not stalled.
// The 400/100/4/1-year split of the day count sets most of the depth, one
// reciprocal multiply or one multiply-subtract per stage of that split.
// rst is synchronous and clears only the stage valid bits.
// A stalled result holds the whole pipeline; nothing is dropped or repeated.
module datetime_add_minutes (
  input  logic              clk,
  input  logic              rst,
  input  logic              ts_valid,
  output logic              ts_stall,
  input  dam_pkg::dam_in_t  ts,
  output logic              res_valid,
  input  logic              res_stall,
  output dam_pkg::dam_out_t res
);
  import dam_pkg::*;

  localparam int NS = 13;

  typedef struct packed {
    logic        vld;
    logic        ok;
    logic        oor;
    logic        leap;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [32:0] offs;
    logic [22:0] q;
    logic [22:0] dby;
    logic [8:0]  cum;
    logic [10:0] tod;
    logic [10:0] r;
    logic [22:0] absd;
    logic [33:0] absm;
    logic [10:0] rem;
    logic        cy;
    logic [24:0] d0;
    logic [7:0]  n400;
    logic [17:0] r1;
    logic [1:0]  n100;
    logic [15:0] r2;
    logic [4:0]  n4;
    logic [10:0] r3;
    logic [1:0]  n1;
    logic [8:0]  doy;
    logic [16:0] yr;
    logic        yleap;
    dam_out_t    out;
  } pipe_t;

  pipe_t st [1:NS];
  pipe_t nx [1:NS];
  logic  en;

  logic [28:0]        yq_prod;
  logic [13:0]        y100;
  logic [13:0]        ymod100;
  logic [32:0]        offs_in;
  logic [56:0]        q_prod;
  logic [13:0]        p;
  logic [28:0]        p_prod;
  logic [13:0]        p100;
  logic [11:0]        tsum;
  logic signed [24:0] d;
  logic signed [31:0] dw;
  logic [50:0]        prod400;
  logic [36:0]        prod100;
  logic [2:0]         n100_raw;
  logic [32:0]        prod4;
  logic [22:0]        prod1;
  logic [2:0]         n1_raw;
  logic [3:0]         mcnt;
  logic [3:0]         mres;
  logic [8:0]         dres;
  logic [21:0]        hprod;
  logic [4:0]         hr;

  assign en        = !(st[NS].vld && res_stall);
  assign ts_stall  = st[NS].vld && res_stall;
  assign res_valid = st[NS].vld;
  assign res       = st[NS].out;

  always_comb begin
    // stage 1: validity, offset bias and day quotient
    nx[1]        = st[1];
    yq_prod      = 29'(ts.year) * 29'(M100);
    y100         = 14'(yq_prod >> K100);
    ymod100      = 14'(ts.year - 14'(28'(y100) * 28'd100));
    nx[1].leap   = (ts.year[1:0] == 2'd0) && ((ymod100 != 14'd0) || (y100[1:0] == 2'd0));
    nx[1].ok     = (ts.month >= 4'd1) && (ts.month <= 4'd12) && (ts.year >= 14'd1)
                   && (32'(ts.year) <= 32'(MAX_YEAR)) && (ts.hour <= 5'd23)
                   && (ts.minute <= 6'd59) && (ts.day >= 5'd1)
                   && (ts.day <= month_len(ts.month, nx[1].leap));
    nx[1].vld    = ts_valid;
    nx[1].year   = ts.year;
    nx[1].month  = ts.month;
    nx[1].day    = ts.day;
    nx[1].hour   = ts.hour;
    nx[1].minute = ts.minute;
    offs_in      = 33'($signed(ts.offset_minutes)) + 33'(OFF_BIAS_DAYS * 64'd1440);
    nx[1].offs   = offs_in;
    q_prod       = 57'(offs_in >> 5) * 57'(M45);
    nx[1].q      = 23'(q_prod >> K45);

    // stage 2: days before the year, days before the month, time of day, offset minute remainder
    nx[2]        = st[1];
    p            = st[1].year - 14'd1;
    p_prod       = 29'(p) * 29'(M100);
    p100         = 14'(p_prod >> K100);
    nx[2].dby    = 23'(23'(p) * 23'd365) + 23'(p >> 2) - 23'(p100) + 23'(p100 >> 2);
    nx[2].cum    = cum_before(st[1].month, st[1].leap);
    nx[2].tod    = 11'(11'(st[1].hour) * 11'd60) + 11'(st[1].minute);
    nx[2].r      = 11'(st[1].offs - 33'(33'(st[1].q) * 33'd1440));

    // stage 3: absolute day and minutes, minute carry
    nx[3]        = st[2];
    nx[3].absd   = st[2].dby + 23'(st[2].cum) + 23'(st[2].day);
    nx[3].absm   = 34'(34'(nx[3].absd) * 34'd1440) + 34'(st[2].tod);
    tsum         = 12'(st[2].tod) + 12'(st[2].r);
    nx[3].cy     = tsum >= 12'd1440;
    nx[3].rem    = nx[3].cy ? 11'(tsum - 12'd1440) : 11'(tsum);

    // stage 4: result day and range check
    nx[4]        = st[3];
    d            = $signed(25'(st[3].absd)) + $signed(25'(st[3].q))
                   - $signed(25'(OFF_BIAS_DAYS)) + $signed({24'd0, st[3].cy});
    dw           = 32'(d);
    nx[4].oor    = (dw < 32'sd1) || (dw > 32'(DAY_MAX));
    nx[4].d0     = 25'(d - 25'sd1);

    // stage 5: 400-year cycles
    nx[5]        = st[4];
    prod400      = 51'(st[4].d0) * 51'(M400Y);
    nx[5].n400   = 8'(prod400 >> K400Y);

    // stage 6
    nx[6]        = st[5];
    nx[6].r1     = 18'(st[5].d0 - 25'(25'(st[5].n400) * 25'd146097));

    // stage 7: centuries, clamp the last day of a 400-year cycle
    nx[7]        = st[6];
    prod100      = 37'(st[6].r1) * 37'(M100Y);
    n100_raw     = 3'(prod100 >> K100Y);
    nx[7].n100   = (n100_raw > 3'd3) ? 2'd3 : 2'(n100_raw);

    // stage 8
    nx[8]        = st[7];
    nx[8].r2     = 16'(st[7].r1 - 18'(18'(st[7].n100) * 18'd36524));

    // stage 9: 4-year groups
    nx[9]        = st[8];
    prod4        = 33'(st[8].r2) * 33'(M4Y);
    nx[9].n4     = 5'(prod4 >> K4Y);

    // stage 10
    nx[10]       = st[9];
    nx[10].r3    = 11'(st[9].r2 - 16'(16'(st[9].n4) * 16'd1461));

    // stage 11: single years, clamp the leap day at the end of a group
    nx[11]       = st[10];
    prod1        = 23'(st[10].r3) * 23'(M1Y);
    n1_raw       = 3'(prod1 >> K1Y);
    nx[11].n1    = (n1_raw > 3'd3) ? 2'd3 : 2'(n1_raw);

    // stage 12: year and day of year
    nx[12]       = st[11];
    nx[12].doy   = 9'(st[11].r3 - 11'(11'(st[11].n1) * 11'd365));
    nx[12].yr    = 17'(17'(st[11].n400) * 17'd400) + 17'(17'(st[11].n100) * 17'd100)
                   + 17'(17'(st[11].n4) * 17'd4) + 17'(st[11].n1) + 17'd1;
    nx[12].yleap = (st[11].n1 == 2'd3) && ((st[11].n4 != 5'd24) || (st[11].n100 == 2'd3));

    // stage 13: month search and result word
    nx[13]       = st[12];
    mcnt         = 4'd0;
    for (int m = 2; m <= 12; m++) begin
      if (st[12].doy >= cum_before(4'(m), st[12].yleap)) mcnt = mcnt + 4'd1;
    end
    mres         = mcnt + 4'd1;
    dres         = st[12].doy - cum_before(mres, st[12].yleap) + 9'd1;
    hprod        = 22'(st[12].rem) * 22'(M60);
    hr           = 5'(hprod >> K60);
    nx[13].out.input_valid      = st[12].ok;
    nx[13].out.absolute_minutes = st[12].ok ? st[12].absm[32:0] : 33'd0;
    nx[13].out.out_of_range     = st[12].ok && st[12].oor;
    if (st[12].ok && !st[12].oor) begin
      nx[13].out.res_day    = 5'(dres);
      nx[13].out.res_month  = mres;
      nx[13].out.res_year   = st[12].yr[13:0];
      nx[13].out.res_hour   = hr;
      nx[13].out.res_minute = 6'(st[12].rem - 11'(11'(hr) * 11'd60));
    end else begin
      nx[13].out.res_day    = 5'd0;
      nx[13].out.res_month  = 4'd0;
      nx[13].out.res_year   = 14'd0;
      nx[13].out.res_hour   = 5'd0;
      nx[13].out.res_minute = 6'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= NS; k++) st[k].vld <= 1'b0;
    end else if (en) begin
      for (int k = 1; k <= NS; k++) st[k] <= nx[k];
    end
  end

endmodule
